FILE: src/srtc_pkg.sv
// Shared types, constants and helpers for the serial clock chip port.
package srtc_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [5:0] CTL_DSTROBE = 6'h02;
    localparam logic [5:0] CTL_CMD     = 6'h1c;
    localparam logic [5:0] CTL_CSTROBE = 6'h20;
    localparam logic [5:0] CMD_ENSR    = 6'h04;
    localparam logic [5:0] CMD_GET     = 6'h0c;
    localparam logic [5:0] CMD_RATE    = 6'h10;

    localparam int IMAGE_BITS = 40;
    localparam int PTR_W      = $clog2(IMAGE_BITS);

    localparam logic [2:0] RATE_64HZ   = 3'd4;
    localparam logic [2:0] RATE_256HZ  = 3'd5;
    localparam logic [2:0] RATE_2048HZ = 3'd6;
    localparam logic [2:0] RATE_32HZ   = 3'd7;

    localparam logic [IMAGE_BITS-1:0] IMAGE_RESET =
        {8'h76, 8'h25, 8'h12, 8'h34, 8'h25};

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] write_value;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [2:0] weekday;
    } in_item_t;

    typedef struct packed {
        logic read_bit;
        logic irq;
    } out_item_t;

    // tens by reciprocal multiply, exact for six-bit values
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  tens;
        logic [5:0]  ones;
        prod = {8'd0, v} * 14'd205;
        tens = prod[13:11];
        ones = v - 6'({3'd0, tens} * 6'd10);
        return {1'b0, tens, ones[3:0]};
    endfunction

    // period length in ticks; zero when the periodic interrupt is off
    function automatic logic [6:0] period_ticks(input logic [2:0] sel);
        logic [6:0] p;
        case (sel)
            RATE_64HZ:   p = 7'd32;
            RATE_256HZ:  p = 7'd8;
            RATE_2048HZ: p = 7'd1;
            RATE_32HZ:   p = 7'd64;
            default:     p = 7'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: src/srtc_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface srtc_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/srtc_core.sv
// Chip state registers and the per-transfer update and result logic.
module srtc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  srtc_pkg::in_item_t item,
    output srtc_pkg::out_item_t result
);
    import srtc_pkg::*;

    logic [5:0]            last_control_reg, last_control_next;
    logic [PTR_W-1:0]      bit_pointer_reg, bit_pointer_next;
    logic [IMAGE_BITS-1:0] time_image_reg, time_image_next;
    logic [2:0]            rate_select_reg, rate_select_next;
    logic [5:0]            rate_divider_reg, rate_divider_next;
    logic                  irq_pending_reg, irq_pending_next;

    logic [5:0]       v;
    logic [5:0]       cmd;
    logic             same;
    logic [PTR_W-1:0] ptr_mid;
    logic [6:0]       period;
    logic [6:0]       div_inc;
    logic             bit_out;

    always_comb
    begin
        last_control_next = last_control_reg;
        bit_pointer_next  = bit_pointer_reg;
        time_image_next   = time_image_reg;
        rate_select_next  = rate_select_reg;
        rate_divider_next = rate_divider_reg;
        irq_pending_next  = irq_pending_reg;
        bit_out           = 1'b0;

        v       = item.write_value;
        cmd     = v & CTL_CMD;
        same    = cmd == (last_control_reg & CTL_CMD);
        ptr_mid = bit_pointer_reg;
        period  = period_ticks(rate_select_reg);
        div_inc = {1'b0, rate_divider_reg} + 7'd1;

        unique case (item.action)
            ACT_WRITE:
            begin
                if (same && (v & CTL_CSTROBE) == 6'd0
                         && (last_control_reg & CTL_CSTROBE) != 6'd0)
                begin
                    if (cmd == CMD_ENSR)
                    begin
                        ptr_mid = '0;
                    end
                    else if (cmd == CMD_GET)
                    begin
                        time_image_next = {
                            item.month_index, 1'b0, item.weekday,
                            to_bcd({1'b0, item.day_of_month}),
                            to_bcd({1'b0, item.hours}),
                            to_bcd(item.minutes),
                            to_bcd(item.seconds)};
                    end
                    else if (cmd >= CMD_RATE)
                    begin
                        rate_select_next  = cmd[4:2];
                        rate_divider_next = '0;
                    end
                end
                bit_pointer_next = ptr_mid;
                if (same && (v & CTL_DSTROBE) == 6'd0
                         && (last_control_reg & CTL_DSTROBE) != 6'd0)
                begin
                    if (ptr_mid == PTR_W'(IMAGE_BITS - 1))
                        bit_pointer_next = '0;
                    else
                        bit_pointer_next = ptr_mid + PTR_W'(1);
                end
                last_control_next = v;
            end
            ACT_READ:
            begin
                irq_pending_next = 1'b0;
                bit_out          = time_image_reg[bit_pointer_reg];
            end
            ACT_TICK:
            begin
                if (period != 7'd0)
                begin
                    if (div_inc >= period)
                    begin
                        rate_divider_next = '0;
                        irq_pending_next  = 1'b1;
                    end
                    else
                    begin
                        rate_divider_next = div_inc[5:0];
                    end
                end
            end
            ACT_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        result.read_bit = bit_out;
        result.irq      = irq_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_control_reg <= '0;
            bit_pointer_reg  <= '0;
            time_image_reg   <= IMAGE_RESET;
            rate_select_reg  <= '0;
            rate_divider_reg <= '0;
            irq_pending_reg  <= 1'b0;
        end
        else if (fire)
        begin
            last_control_reg <= last_control_next;
            bit_pointer_reg  <= bit_pointer_next;
            time_image_reg   <= time_image_next;
            rate_select_reg  <= rate_select_next;
            rate_divider_reg <= rate_divider_next;
            irq_pending_reg  <= irq_pending_next;
        end
    end

endmodule

FILE: src/serial_rtc_shift_interface.sv
// Top level: input stage, chip state core and result register.
//
//  channel  direction  payload
//  in_ch    sink       action, write_value, seconds .. weekday
//  out_ch   source     read_bit, irq
//
// One transfer per cycle while the output is not stalled; each item is registered
// in the input stage and then in the result register, from which it is taken.
// The state update happens as the item moves from the input stage into
// the result register, so a stalled output holds the input stage only.
// rst_n clears the valid flags and core state asynchronously; time image resets to its default.
module serial_rtc_shift_interface (
    input logic        clk,
    input logic        rst_n,
    srtc_chan_if.sink   in_ch,
    srtc_chan_if.source out_ch
);
    import srtc_pkg::*;

    logic      stage_valid_reg;
    in_item_t  stage_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance;

    assign advance     = stage_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                stage_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            stage_item_reg <= in_ch.payload;
        if (advance)
            out_item_reg <= core_result;
    end

    srtc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (stage_item_reg),
        .result (core_result)
    );

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg)
        else $error("input stage dropped a stalled transfer");

    a_read_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_item_reg.action == ACT_READ |=> !out_ch.payload.irq)
        else $error("irq not cleared by read");

    a_bit_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_item_reg.action != ACT_READ |=> !out_ch.payload.read_bit)
        else $error("read_bit set on non-read transfer");

    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> stage_valid_reg && out_valid_reg)
        else $error("input stalled with room available");

endmodule
